// ===== sv/mhs_pkg.sv =====
// Shared constants, types and helpers of the min-hash segmenter.
// No dependencies; used by every module of the block by scoped name.
package mhs_pkg;

  localparam int HashBytes  = 32;
  localparam int FpBits     = HashBytes * 8;
  localparam int FpWordW    = 64;
  localparam int NibW       = 4;
  localparam int CmpSteps   = FpBits / NibW;
  localparam int CmpCntW    = $clog2(CmpSteps);
  localparam int ModSteps   = FpWordW;
  localparam int ModCntW    = $clog2(ModSteps);

  localparam int SizeW      = 25;
  localparam int CountW     = 24;
  localparam int SegIdW     = 32;
  localparam int SrvW       = 4;
  localparam int ModW       = 5;
  localparam int ItemW      = 12;
  localparam int LimitW     = 24;
  localparam int PatW       = 31;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 31;
  localparam int InDataW    = FpBits;
  localparam int OutDataW   = 320;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [7:0]        ZeroChar = 8'h30;
  localparam logic [ModW-1:0]   ModMin   = 5'd1;
  localparam logic [ModW-1:0]   ModMax   = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SERVER_COUNT     = 3'd0,
    CFG_ITEM_BYTES       = 3'd1,
    CFG_MIN_SEGMENT      = 3'd2,
    CFG_MAX_SEGMENT      = 3'd3,
    CFG_BOUNDARY_MASK    = 3'd4,
    CFG_BOUNDARY_PATTERN = 3'd5
  } cfg_idx_e;

  // status of a serial unit: running, and one-cycle completion flag
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [FpWordW-1:0] swap64(input logic [FpWordW-1:0] v);
    logic [FpWordW-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[FpWordW-8-8*i +: 8];
    end
    return r;
  endfunction

endpackage

// ===== sv/mhs_cmp.sv =====
// Nibble-serial lexicographic compare of a fingerprint against the stored minimum.
// Holds the segment minimum; depends on mhs_pkg.
module mhs_cmp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      clear_i,
  input  logic [mhs_pkg::FpBits-1:0] cand_i,
  output mhs_pkg::unit_stat_t       stat_o,
  output logic [mhs_pkg::FpBits-1:0] min_o
);

  logic [mhs_pkg::FpBits-1:0]  cand_q, min_q;
  logic [mhs_pkg::FpBits-1:0]  cand_rot, min_rot;
  logic [mhs_pkg::CmpCntW-1:0] cnt_q;
  logic                        busy_q, done_q, decided_q, lt_q;
  logic [mhs_pkg::NibW-1:0]    cand_nib, min_nib;
  logic                        diff, lt_now, lt_fin, last_step;

  assign cand_nib  = cand_q[mhs_pkg::FpBits-1 -: mhs_pkg::NibW];
  assign min_nib   = min_q[mhs_pkg::FpBits-1 -: mhs_pkg::NibW];
  assign cand_rot  = {cand_q[mhs_pkg::FpBits-mhs_pkg::NibW-1:0], cand_nib};
  assign min_rot   = {min_q[mhs_pkg::FpBits-mhs_pkg::NibW-1:0], min_nib};
  assign diff      = cand_nib != min_nib;
  assign lt_now    = cand_nib < min_nib;
  assign lt_fin    = decided_q ? lt_q : (diff & lt_now);
  assign last_step = cnt_q == mhs_pkg::CmpCntW'(mhs_pkg::CmpSteps - 1);

  // rotate the candidate; a full pass brings it back in place
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cand_q <= cand_i;
    end else if (busy_q) begin
      cand_q <= cand_rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '1;
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      decided_q <= 1'b0;
      lt_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q     <= '0;
        busy_q    <= 1'b1;
        decided_q <= 1'b0;
        lt_q      <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        // first differing nibble from the top decides
        if (!decided_q && diff) begin
          decided_q <= 1'b1;
          lt_q      <= lt_now;
        end
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          min_q  <= lt_fin ? cand_rot : min_rot;
        end else begin
          min_q  <= min_rot;
        end
      end else if (clear_i) begin
        min_q <= '1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign min_o       = min_q;

endmodule

// ===== sv/mhs_mod.sv =====
// Bit-serial remainder of a 64-bit value by a modulus of 1..16.
// Restoring step per cycle, MSB first; depends on mhs_pkg.
module mhs_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mhs_pkg::FpWordW-1:0] value_i,
  input  logic [mhs_pkg::ModW-1:0]    modulus_i,
  output mhs_pkg::unit_stat_t         stat_o,
  output logic [mhs_pkg::SrvW-1:0]    rem_o
);

  logic [mhs_pkg::FpWordW-1:0] val_q;
  logic [mhs_pkg::ModW-1:0]    mod_q;
  logic [mhs_pkg::SrvW-1:0]    rem_q;
  logic [mhs_pkg::ModCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [mhs_pkg::ModW-1:0]    trial, rem_next;

  // remainder stays below the modulus, so it fits four bits
  assign trial    = {rem_q, val_q[mhs_pkg::FpWordW-1]};
  assign rem_next = (trial >= mod_q) ? trial - mod_q : trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      mod_q <= modulus_i;
    end else if (busy_q) begin
      val_q <= {val_q[mhs_pkg::FpWordW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_next[mhs_pkg::SrvW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mhs_pkg::ModCntW'(mhs_pkg::ModSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ===== sv/min_hash_segmenter_top.sv =====
// Min-hash content-defined segmenter: sequencer, segment counters, config, output beat.
// Depends on mhs_pkg, mhs_cmp and mhs_mod.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata fp_word0..3, tlast last_chunk
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata id, count, server, min words
//  cfg       | in  | cfg_we_i (no wait)            | cfg_idx_i, cfg_data_i
//
// An item whose segment stays open is accepted, runs the nibble-serial minimum compare,
// is handed over on the compare's done flag and then loads the output register. A
// closing item also runs the bit-serial server-index remainder and its done hand-over
// before the load.
// One item is in work at a time; the next one is taken while the result waits.
// A stalled output holds the finished item until the output register frees up.
// Reset restores the register defaults and an empty segment at once.
module min_hash_segmenter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fp_word0 [63:0], fp_word1 [127:64], fp_word2 [191:128], fp_word3 [255:192]
  input  logic [mhs_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // segment_id [31:0], chunks_in_segment [55:32], server_index [59:56],
  // min_word0 [123:60], min_word1 [187:124], min_word2 [251:188],
  // min_word3 [315:252], zero [319:316]
  output logic [mhs_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [mhs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mhs_pkg::CfgDataW-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_MOD  = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [mhs_pkg::ModW-1:0]   server_count_q;
  logic [mhs_pkg::ItemW-1:0]  item_bytes_q;
  logic [mhs_pkg::LimitW-1:0] min_seg_q, max_seg_q;
  logic [mhs_pkg::PatW-1:0]   mask_q, pattern_q;

  logic [mhs_pkg::SizeW-1:0]  seg_bytes_q;
  logic [mhs_pkg::CountW-1:0] count_q;
  logic [mhs_pkg::SegIdW-1:0] seg_id_q;
  logic                       close_q;

  logic                       out_valid_q, out_last_q;
  logic [mhs_pkg::OutDataW-1:0] out_data_q;

  logic                       in_acc, load;
  logic [mhs_pkg::FpBits-1:0] cand;
  logic [mhs_pkg::FpWordW-1:0] w0, w1, w2, w3;
  logic [mhs_pkg::FpWordW-1:0] w0_le;
  logic [mhs_pkg::SizeW-1:0]  size_sum;
  logic [31:0]                head;
  logic                       pattern_hit, zeros_hit, close_now;
  logic [mhs_pkg::ModW-1:0]   modulus;

  mhs_pkg::unit_stat_t        cmp_stat, mod_stat;
  logic                       cmp_start, mod_start;
  logic [mhs_pkg::FpBits-1:0] min_fp;
  logic [mhs_pkg::SrvW-1:0]   rem;

  assign w0   = s_axis_tdata[0*mhs_pkg::FpWordW +: mhs_pkg::FpWordW];
  assign w1   = s_axis_tdata[1*mhs_pkg::FpWordW +: mhs_pkg::FpWordW];
  assign w2   = s_axis_tdata[2*mhs_pkg::FpWordW +: mhs_pkg::FpWordW];
  assign w3   = s_axis_tdata[3*mhs_pkg::FpWordW +: mhs_pkg::FpWordW];
  assign cand = {w0, w1, w2, w3};

  assign s_axis_tready = state_q == S_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == S_LOAD) && (!out_valid_q || m_axis_tready);

  // boundary tests on the incoming beat
  assign size_sum    = seg_bytes_q + mhs_pkg::SizeW'(item_bytes_q);
  assign w0_le       = mhs_pkg::swap64(w0);
  assign head        = w0_le[31:0];
  assign pattern_hit = (head[mhs_pkg::PatW-1:0] & mask_q) == pattern_q;
  assign zeros_hit   = (w2[7:0] == mhs_pkg::ZeroChar) && (w3 == {8{mhs_pkg::ZeroChar}});
  assign close_now   = (pattern_hit && (size_sum >= mhs_pkg::SizeW'(min_seg_q)))
                    || (size_sum > mhs_pkg::SizeW'(max_seg_q))
                    || zeros_hit || s_axis_tlast;

  assign modulus = (server_count_q == '0)           ? mhs_pkg::ModMin :
                   (server_count_q > mhs_pkg::ModMax) ? mhs_pkg::ModMax : server_count_q;

  assign cmp_start = in_acc;
  assign mod_start = (state_q == S_CMP) && cmp_stat.done && close_q;

  mhs_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmp_start),
    .clear_i (load && close_q),
    .cand_i  (cand),
    .stat_o  (cmp_stat),
    .min_o   (min_fp)
  );

  mhs_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .value_i   (mhs_pkg::swap64(min_fp[mhs_pkg::FpBits-1 -: mhs_pkg::FpWordW])),
    .modulus_i (modulus),
    .stat_o    (mod_stat),
    .rem_o     (rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_CMP;
      S_CMP: begin
        if (cmp_stat.done) state_d = close_q ? S_MOD : S_LOAD;
      end
      S_MOD:  if (mod_stat.done) state_d = S_LOAD;
      S_LOAD: if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      server_count_q <= 5'd1;
      item_bytes_q   <= 12'd64;
      min_seg_q      <= 24'd1048576;
      max_seg_q      <= 24'd4194304;
      mask_q         <= 31'd255;
      pattern_q      <= '0;
      seg_bytes_q    <= '0;
      count_q        <= '0;
      seg_id_q       <= '0;
      close_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mhs_pkg::CFG_SERVER_COUNT:     server_count_q <= cfg_data_i[mhs_pkg::ModW-1:0];
          mhs_pkg::CFG_ITEM_BYTES:       item_bytes_q   <= cfg_data_i[mhs_pkg::ItemW-1:0];
          mhs_pkg::CFG_MIN_SEGMENT:      min_seg_q      <= cfg_data_i[mhs_pkg::LimitW-1:0];
          mhs_pkg::CFG_MAX_SEGMENT:      max_seg_q      <= cfg_data_i[mhs_pkg::LimitW-1:0];
          mhs_pkg::CFG_BOUNDARY_MASK:    mask_q         <= cfg_data_i;
          mhs_pkg::CFG_BOUNDARY_PATTERN: pattern_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        seg_bytes_q <= size_sum;
        close_q     <= close_now;
        if (count_q != mhs_pkg::CountMax) count_q <= count_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        // close: start a fresh segment
        if (close_q) begin
          seg_bytes_q <= '0;
          count_q     <= '0;
          seg_id_q    <= seg_id_q + 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_last_q <= close_q;
      out_data_q <= {4'b0,
                     close_q ? min_fp[0*mhs_pkg::FpWordW +: mhs_pkg::FpWordW] : 64'b0,
                     close_q ? min_fp[1*mhs_pkg::FpWordW +: mhs_pkg::FpWordW] : 64'b0,
                     close_q ? min_fp[2*mhs_pkg::FpWordW +: mhs_pkg::FpWordW] : 64'b0,
                     close_q ? min_fp[3*mhs_pkg::FpWordW +: mhs_pkg::FpWordW] : 64'b0,
                     close_q ? rem : 4'b0,
                     count_q,
                     seg_id_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== sv/mhs_chk.sv =====
// Port-level checker of the min-hash segmenter, bound to the top level.
// Depends on mhs_pkg and min_hash_segmenter_top.
module mhs_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mhs_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // one item in work: intake closes right after a beat is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // open segment reports no minimum and no server
  a_open_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[mhs_pkg::OutDataW-1:56] == '0)
    else $error("open segment carries minimum or server index");

  // every result counts at least its own chunk
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:32] != '0)
    else $error("chunk count is zero");

endmodule

bind min_hash_segmenter_top mhs_chk u_mhs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/testbench.sv =====
// Self-checking bench for min_hash_segmenter_top: directed boundary cases, then random
// chunk streams over several register settings, checked beat by beat against a predictor.
// Depends on mhs_pkg and min_hash_segmenter_top.
module testbench;

  typedef logic [3:0][63:0] fp_t;

  typedef struct packed {
    logic [31:0] seg_id;
    logic        seg_end;
    logic [23:0] chunks;
    logic [3:0]  server;
    fp_t         min_fp;
  } seg_report_t;

  localparam int unsigned CycleLimit = 10_000_000;
  localparam int          TailCycles = 140;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [mhs_pkg::InDataW-1:0]         s_axis_tdata;
  logic                                s_axis_tlast;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [mhs_pkg::OutDataW-1:0]        m_axis_tdata;
  logic                                m_axis_tlast;
  logic                                cfg_we_i;
  logic [mhs_pkg::CfgIdxW-1:0]         cfg_idx_i;
  logic [mhs_pkg::CfgDataW-1:0]        cfg_data_i;

  // predictor copy of the registers
  logic [4:0]  servers;
  logic [11:0] chunk_bytes;
  logic [23:0] size_floor;
  logic [23:0] size_ceiling;
  logic [30:0] head_mask;
  logic [30:0] head_pattern;

  // predictor copy of the segment state
  fp_t         seg_min;
  logic [24:0] seg_size;
  logic [23:0] seg_chunks;
  logic [31:0] seg_number;

  seg_report_t segment_reports[$];
  fp_t         prev_fp;
  int          mismatches;
  int          gap_pct;
  int          stall_pct;
  int          stall_left;
  int unsigned cycle_count;

  min_hash_segmenter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] byte_reverse(input logic [63:0] w);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = w[56-8*i +: 8];
    end
    return r;
  endfunction

  // place a little-endian head value in fingerprint bytes 0..3
  function automatic fp_t with_head(input fp_t fp, input logic [31:0] head);
    fp_t r;
    r = fp;
    r[0][63:32] = {head[7:0], head[15:8], head[23:16], head[31:24]};
    return r;
  endfunction

  // bytes 23..31 all ASCII zero
  function automatic fp_t with_zero_tail(input fp_t fp);
    fp_t r;
    r = fp;
    r[2][7:0] = mhs_pkg::ZeroChar;
    r[3] = {8{mhs_pkg::ZeroChar}};
    return r;
  endfunction

  function automatic fp_t random_fp();
    fp_t r;
    for (int w = 0; w < 4; w++) begin
      r[w] = {$urandom, $urandom};
    end
    return r;
  endfunction

  task automatic predict_segment(input fp_t fp, input logic last);
    seg_report_t rep;
    logic [63:0] swapped;
    logic [31:0] head;
    logic [4:0]  modulus;
    logic        pattern_hit;
    logic        tail_hit;
    logic        closes;
    seg_size = seg_size + 25'(chunk_bytes);
    if (seg_chunks != '1) begin
      seg_chunks = seg_chunks + 24'd1;
    end
    // word 0 is the most significant in the ordering
    if ({fp[0], fp[1], fp[2], fp[3]} < {seg_min[0], seg_min[1], seg_min[2], seg_min[3]}) begin
      seg_min = fp;
    end
    swapped = byte_reverse(fp[0]);
    head = swapped[31:0];
    pattern_hit = (head[30:0] & head_mask) == head_pattern;
    tail_hit = (fp[2][7:0] == mhs_pkg::ZeroChar) && (fp[3] == {8{mhs_pkg::ZeroChar}});
    closes = (pattern_hit && seg_size >= 25'(size_floor)) ||
             (seg_size > 25'(size_ceiling)) || tail_hit || last;
    rep = '0;
    rep.seg_id = seg_number;
    rep.seg_end = closes;
    rep.chunks = seg_chunks;
    if (closes) begin
      modulus = servers;
      if (modulus == 5'd0) begin
        modulus = 5'd1;
      end
      if (modulus > 5'd16) begin
        modulus = 5'd16;
      end
      swapped = byte_reverse(seg_min[0]);
      rep.server = 4'(swapped % 64'(modulus));
      rep.min_fp = seg_min;
      seg_number = seg_number + 32'd1;
      seg_min = '1;
      seg_size = '0;
      seg_chunks = '0;
    end
    segment_reports.push_back(rep);
  endtask

  task automatic send_chunk(input fp_t fp, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= fp;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_segment(fp, last);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 150)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (segment_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input mhs_pkg::cfg_idx_e idx, input logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic set_registers(input logic [4:0] srv, input logic [11:0] nbytes,
                               input logic [23:0] lo, input logic [23:0] hi,
                               input logic [30:0] mask, input logic [30:0] pat);
    wait_drained();
    write_reg(mhs_pkg::CFG_SERVER_COUNT, 31'(srv));
    write_reg(mhs_pkg::CFG_ITEM_BYTES, 31'(nbytes));
    write_reg(mhs_pkg::CFG_MIN_SEGMENT, 31'(lo));
    write_reg(mhs_pkg::CFG_MAX_SEGMENT, 31'(hi));
    write_reg(mhs_pkg::CFG_BOUNDARY_MASK, mask);
    write_reg(mhs_pkg::CFG_BOUNDARY_PATTERN, pat);
    cfg_we_i <= 1'b0;
    servers = srv;
    chunk_bytes = nbytes;
    size_floor = lo;
    size_ceiling = hi;
    head_mask = mask;
    head_pattern = pat;
  endtask

  // reset settings: pattern rule unreachable early, so only tail and last close
  task automatic test_default_settings();
    fp_t fp;
    send_chunk('1, 1'b0);
    send_chunk('0, 1'b0);
    send_chunk('0, 1'b1);
    send_chunk(with_zero_tail(random_fp()), 1'b0);
    fp = with_zero_tail(random_fp());
    fp[2][7:0] = 8'h31;
    send_chunk(fp, 1'b0);
    // the next two chunks share their leading words and differ only in the last word
    fp = '1;
    fp[1] = 64'h0123_4567_89ab_cdef;
    send_chunk(fp, 1'b0);
    fp[3] = 64'hffff_ffff_ffff_fffe;
    send_chunk(fp, 1'b1);
  endtask

  task automatic test_boundary_rules();
    set_registers(5'd16, 12'd4095, 24'd0, 24'hFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    // bit 31 of the head lies outside the mask
    send_chunk(with_head(random_fp(), 32'hFFFF_FFFF), 1'b0);
    send_chunk(with_head(random_fp(), 32'h7FFF_FFFE), 1'b0);
    set_registers(5'd31, 12'd0, 24'hFFFFFF, 24'd0, 31'd0, 31'd0);
    send_chunk(random_fp(), 1'b0);
    send_chunk(random_fp(), 1'b0);
    send_chunk(random_fp(), 1'b1);
    set_registers(5'd0, 12'd1, 24'd1, 24'd0, 31'd0, 31'd1);
    send_chunk(random_fp(), 1'b0);
  endtask

  task automatic test_size_limits();
    set_registers(5'd5, 12'd3, 24'd6, 24'd9, 31'hFF, 31'h5A);
    send_chunk(with_head(random_fp(), 32'h5A), 1'b0);
    send_chunk(with_head(random_fp(), 32'h0), 1'b0);
    send_chunk(with_head(random_fp(), 32'h1234_565A), 1'b0);
    repeat (4) send_chunk(with_head(random_fp(), 32'h0), 1'b0);
  endtask

  task automatic send_random_chunk();
    fp_t  fp;
    logic last;
    if ($urandom_range(99) < 5) begin
      fp = prev_fp;
    end else begin
      for (int w = 0; w < 4; w++) begin
        case ($urandom_range(9))
          0: fp[w] = seg_min[w];
          1: fp[w] = '1;
          2: fp[w] = 64'($urandom_range(255));
          default: fp[w] = {$urandom, $urandom};
        endcase
      end
    end
    if ($urandom_range(3) == 0) begin
      fp = with_head(fp, ($urandom & ~{1'b0, head_mask}) | {1'b0, head_pattern});
    end
    if ($urandom_range(19) == 0) begin
      fp = with_zero_tail(fp);
    end
    last = ($urandom_range(24) == 0);
    prev_fp = fp;
    send_chunk(fp, last);
  endtask

  task automatic test_random_traffic();
    logic [4:0]  srv;
    logic [11:0] nbytes;
    logic [23:0] lo;
    logic [23:0] hi;
    logic [30:0] mask;
    logic [30:0] pat;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0: srv = $urandom_range(1) ? 5'd0 : 5'd31;
        default: srv = 5'($urandom_range(1, 16));
      endcase
      case ($urandom_range(4))
        0: nbytes = 12'd1;
        1: nbytes = 12'd4095;
        2: nbytes = 12'd0;
        default: nbytes = 12'($urandom_range(1, 300));
      endcase
      case ($urandom_range(3))
        0: lo = 24'd0;
        1: lo = 24'hFFFFFF;
        default: lo = 24'($urandom_range(0, 16 * (nbytes + 1)));
      endcase
      case ($urandom_range(3))
        0: hi = 24'd0;
        1: hi = 24'hFFFFFF;
        default: hi = 24'($urandom_range(nbytes, 40 * (nbytes + 1)));
      endcase
      case ($urandom_range(3))
        0: mask = 31'd0;
        1: mask = 31'h7FFFFFFF;
        default: mask = 31'((32'd1 << $urandom_range(1, 6)) - 1);
      endcase
      pat = ($urandom_range(4) == 0) ? 31'($urandom) : (31'($urandom) & mask);
      set_registers(srv, nbytes, lo, hi, mask, pat);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      repeat (250) send_random_chunk();
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    seg_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (segment_reports.size() == 0) begin
        $error("result beat with no segment report pending");
        mismatches++;
      end else begin
        want = segment_reports.pop_front();
        check_field("segment_id", 64'(want.seg_id), 64'(m_axis_tdata[31:0]));
        check_field("segment_end", 64'(want.seg_end), 64'(m_axis_tlast));
        check_field("chunks_in_segment", 64'(want.chunks), 64'(m_axis_tdata[55:32]));
        check_field("server_index", 64'(want.server), 64'(m_axis_tdata[59:56]));
        for (int i = 0; i < 4; i++) begin
          check_field($sformatf("min_word%0d", i), want.min_fp[i],
                      m_axis_tdata[60 + 64*i +: 64]);
        end
      end
    end
  end

  // hold the output ready low for random stretches
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(0, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = mhs_pkg::CFG_SERVER_COUNT;
    cfg_data_i = '0;
    mismatches = 0;
    gap_pct = 0;
    stall_pct = 0;
    stall_left = 0;
    cycle_count = 0;
    prev_fp = '1;
    servers = 5'd1;
    chunk_bytes = 12'd64;
    size_floor = 24'd1048576;
    size_ceiling = 24'd4194304;
    head_mask = 31'd255;
    head_pattern = 31'd0;
    seg_min = '1;
    seg_size = '0;
    seg_chunks = '0;
    seg_number = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_settings();
    test_boundary_rules();
    test_size_limits();
    test_random_traffic();
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
